### hdl/assert_macros.svh
// Assertion macros used by the checker module of the blitter.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, disabled while reset is asserted
`define RTCB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion, active through reset as well
`define RTCB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/rtcb_pkg.sv
// Types, codes and constants of the RLE clip blitter.
// No dependencies; used by every module of the block.
package rtcb_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int ADDR_BITS_DEF  = 24;

	localparam int CFG_COORD_W = 12;
	localparam int CFG_PITCH_W = 13;
	localparam int CFG_IDX_W   = 3;
	localparam int BYTE_W      = 8;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [BYTE_W-1:0] TRANSPARENT_MIN = 8'd248;
	localparam logic [BYTE_W-1:0] MANY_SKIP_CODE  = 8'd248;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEST_X        = 3'd0,
		REG_DEST_Y        = 3'd1,
		REG_SURFACE_PITCH = 3'd2,
		REG_BITMAP_WIDTH  = 3'd3,
		REG_CLIP_LEFT     = 3'd4,
		REG_CLIP_TOP      = 3'd5,
		REG_CLIP_RIGHT    = 3'd6,
		REG_CLIP_BOTTOM   = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_NOP    = 2'd0,
		CMD_OPAQUE = 2'd1,
		CMD_SKIP   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic              first;
		logic [BYTE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [CFG_COORD_W-1:0] dest_x;
		logic [CFG_COORD_W-1:0] dest_y;
		logic [CFG_PITCH_W-1:0] surface_pitch;
		logic [CFG_COORD_W-1:0] bitmap_width;
		logic [CFG_COORD_W-1:0] clip_left;
		logic [CFG_COORD_W-1:0] clip_top;
		logic [CFG_COORD_W-1:0] clip_right;
		logic [CFG_COORD_W-1:0] clip_bottom;
	} cfg_t;

	typedef enum logic {
		BK_RUN  = 1'b0,
		BK_WRAP = 1'b1
	} back_state_t;

endpackage

### hdl/rtcb_queue.sv
// Short command queue between the front and back of the blitter.
// Depends on rtcb_pkg (cmd_t, QUEUE_DEPTH).
module rtcb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rtcb_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output rtcb_pkg::cmd_t out_cmd
);

	localparam int PTR_W = $clog2(rtcb_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(rtcb_pkg::QUEUE_DEPTH + 1);

	rtcb_pkg::cmd_t   mem_q [rtcb_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != CNT_W'(rtcb_pkg::QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_cmd   = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

### hdl/rtcb_front.sv
// Front end of the blitter: takes body bytes and turns them into commands.
// Depends on rtcb_pkg (cmd_t, code constants).
module rtcb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    code_byte,
	input  logic          first_of_bitmap,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output rtcb_pkg::cmd_t cmd
);

	logic awaiting_q;
	logic awaiting_d;
	logic awaiting_eff;
	logic accept;

	assign in_ready     = cmd_ready;
	assign accept       = in_valid && in_ready;
	assign awaiting_eff = awaiting_q && !first_of_bitmap;

	always_comb begin
		cmd.first  = first_of_bitmap;
		cmd.value  = code_byte;
		cmd.kind   = rtcb_pkg::CMD_NOP;
		awaiting_d = 1'b0;
		if (awaiting_eff) begin
			cmd.kind = rtcb_pkg::CMD_SKIP;
		end else if (code_byte < rtcb_pkg::TRANSPARENT_MIN) begin
			cmd.kind = rtcb_pkg::CMD_OPAQUE;
		end else if (code_byte == rtcb_pkg::MANY_SKIP_CODE) begin
			awaiting_d = 1'b1;
		end else begin
			// short skip of 256 - code pixels
			cmd.kind  = rtcb_pkg::CMD_SKIP;
			cmd.value = 8'd0 - code_byte;
		end
		cmd_valid = in_valid && ((cmd.kind != rtcb_pkg::CMD_NOP) || first_of_bitmap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
		end else if (accept) begin
			awaiting_q <= awaiting_d;
		end
	end

endmodule

### hdl/rtcb_back.sv
// Back end of the blitter: raster position, row wrapping, clip test and
// the output register. Depends on rtcb_pkg (cmd_t, cfg_t, back_state_t).
module rtcb_back #(
	parameter int COORD_BITS = rtcb_pkg::COORD_BITS_DEF,
	parameter int ADDR_BITS  = rtcb_pkg::ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rtcb_pkg::cfg_t       cfg,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  rtcb_pkg::cmd_t       cmd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ADDR_BITS-1:0] out_address,
	output logic [7:0]           out_pixel
);

	localparam int COL_W = COORD_BITS + 1;
	localparam int CMP_W = (COL_W > rtcb_pkg::CFG_COORD_W) ? COL_W : rtcb_pkg::CFG_COORD_W;
	localparam int PROD_W = rtcb_pkg::CFG_COORD_W + rtcb_pkg::CFG_PITCH_W;
	localparam logic [COL_W-1:0] W_FULL = {1'b1, {COORD_BITS{1'b0}}};

	rtcb_pkg::back_state_t state_q, state_d;

	logic [COL_W-1:0]      col_q, col_d, col_cur, col_sum, col_diff;
	logic [COORD_BITS-1:0] row_q, row_d, row_cur;
	logic [ADDR_BITS-1:0]  base_q, base_d, base_cur;
	logic [ADDR_BITS-1:0]  origin_q;
	logic [PROD_W-1:0]     origin_prod;
	logic [COORD_BITS-1:0] width_trunc;
	logic [COL_W-1:0]      width_eff;
	logic                  can_out;
	logic                  pop;
	logic                  in_window;
	logic                  emit;
	logic                  out_valid_q;
	logic [ADDR_BITS-1:0]  out_address_q;
	logic [7:0]            out_pixel_q;

	assign out_valid   = out_valid_q;
	assign out_address = out_address_q;
	assign out_pixel   = out_pixel_q;

	// origin row base, refreshed every cycle from the registers
	assign origin_prod = cfg.dest_y * cfg.surface_pitch;

	always_ff @(posedge clk) begin
		origin_q <= ADDR_BITS'(origin_prod) + ADDR_BITS'(cfg.dest_x);
	end

	assign width_trunc = COORD_BITS'(cfg.bitmap_width);
	assign width_eff   = (width_trunc == '0) ? W_FULL : COL_W'(width_trunc);
	assign can_out     = !out_valid_q || out_ready;

	always_comb begin
		col_cur  = cmd.first ? '0 : col_q;
		row_cur  = cmd.first ? '0 : row_q;
		base_cur = cmd.first ? origin_q : base_q;
		col_sum  = col_cur + ((cmd.kind == rtcb_pkg::CMD_OPAQUE) ? COL_W'(1) : COL_W'(cmd.value));
		col_diff = col_q - width_eff;

		in_window = (CMP_W'(col_cur) >= CMP_W'(cfg.clip_left)) &&
		            (CMP_W'(col_cur) <= CMP_W'(cfg.clip_right)) &&
		            (CMP_W'(row_cur) >= CMP_W'(cfg.clip_top)) &&
		            (CMP_W'(row_cur) <= CMP_W'(cfg.clip_bottom));

		state_d   = state_q;
		col_d     = col_q;
		row_d     = row_q;
		base_d    = base_q;
		cmd_ready = 1'b0;
		pop       = 1'b0;
		emit      = 1'b0;

		case (state_q)
			rtcb_pkg::BK_RUN: begin
				cmd_ready = (cmd.kind != rtcb_pkg::CMD_OPAQUE) || can_out;
				pop       = cmd_valid && cmd_ready;
				if (pop) begin
					row_d  = row_cur;
					base_d = base_cur;
					if (cmd.kind == rtcb_pkg::CMD_NOP) begin
						col_d = col_cur;
					end else begin
						col_d = col_sum;
						if (col_sum >= width_eff) begin
							state_d = rtcb_pkg::BK_WRAP;
						end
					end
					emit = (cmd.kind == rtcb_pkg::CMD_OPAQUE) && in_window;
				end
			end
			rtcb_pkg::BK_WRAP: begin
				col_d  = col_diff;
				row_d  = row_q + COORD_BITS'(1);
				base_d = base_q + ADDR_BITS'(cfg.surface_pitch);
				if (col_diff < width_eff) begin
					state_d = rtcb_pkg::BK_RUN;
				end
			end
			default: begin
				state_d = rtcb_pkg::BK_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rtcb_pkg::BK_RUN;
			col_q       <= '0;
			row_q       <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			base_q  <= base_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_address_q <= base_cur + ADDR_BITS'(col_cur);
			out_pixel_q   <= cmd.value;
		end
	end

endmodule

### hdl/rle_transparent_clip_blit.sv
// RLE transparent sprite blitter with clip window.
// Path: commands pass the queue; writes are held in the back end's output register.
// Throughput: one byte per cycle unless the queue is full; the back end works off a skip
// crossing row ends one row at a time in its single row-subtract step; the 4-entry queue
// covers short ones, longer ones hold s_axis_tready low until the back end catches up.
// Reset: position, run state, queue and output cleared; registers to reset values.
// Depends on rtcb_pkg, rtcb_front, rtcb_queue, rtcb_back.
module rle_transparent_clip_blit #(
	parameter int COORD_BITS = rtcb_pkg::COORD_BITS_DEF,
	parameter int ADDR_BITS  = rtcb_pkg::ADDR_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [7:0]                             s_axis_tdata,  // code_byte
	input  logic                                   s_axis_tuser,  // first_of_bitmap
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [((ADDR_BITS + 8 + 7) / 8) * 8 - 1:0] m_axis_tdata, // write_address, pixel_value
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rtcb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rtcb_pkg::CFG_PITCH_W-1:0]       cfg_data
);

	localparam int OUT_W = ((ADDR_BITS + 8 + 7) / 8) * 8;

	rtcb_pkg::cfg_t       cfg_q;
	rtcb_pkg::cmd_t       front_cmd;
	rtcb_pkg::cmd_t       queue_cmd;
	logic                 front_valid;
	logic                 front_ready;
	logic                 queue_valid;
	logic                 queue_ready;
	logic [ADDR_BITS-1:0] out_address;
	logic [7:0]           out_pixel;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_x        <= '0;
			cfg_q.dest_y        <= '0;
			cfg_q.surface_pitch <= rtcb_pkg::CFG_PITCH_W'(1);
			cfg_q.bitmap_width  <= rtcb_pkg::CFG_COORD_W'(1);
			cfg_q.clip_left     <= '0;
			cfg_q.clip_top      <= '0;
			cfg_q.clip_right    <= '0;
			cfg_q.clip_bottom   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (rtcb_pkg::cfg_reg_t'(cfg_index))
				rtcb_pkg::REG_DEST_X:        cfg_q.dest_x        <= cfg_data[11:0];
				rtcb_pkg::REG_DEST_Y:        cfg_q.dest_y        <= cfg_data[11:0];
				rtcb_pkg::REG_SURFACE_PITCH: cfg_q.surface_pitch <= cfg_data;
				rtcb_pkg::REG_BITMAP_WIDTH:  cfg_q.bitmap_width  <= cfg_data[11:0];
				rtcb_pkg::REG_CLIP_LEFT:     cfg_q.clip_left     <= cfg_data[11:0];
				rtcb_pkg::REG_CLIP_TOP:      cfg_q.clip_top      <= cfg_data[11:0];
				rtcb_pkg::REG_CLIP_RIGHT:    cfg_q.clip_right    <= cfg_data[11:0];
				default:                     cfg_q.clip_bottom   <= cfg_data[11:0];
			endcase
		end
	end

	rtcb_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.code_byte       (s_axis_tdata),
		.first_of_bitmap (s_axis_tuser),
		.cmd_valid       (front_valid),
		.cmd_ready       (front_ready),
		.cmd             (front_cmd)
	);

	rtcb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_cmd    (front_cmd),
		.out_valid (queue_valid),
		.out_ready (queue_ready),
		.out_cmd   (queue_cmd)
	);

	rtcb_back #(
		.COORD_BITS (COORD_BITS),
		.ADDR_BITS  (ADDR_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd_valid   (queue_valid),
		.cmd_ready   (queue_ready),
		.cmd         (queue_cmd),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_address (out_address),
		.out_pixel   (out_pixel)
	);

	assign m_axis_tdata = OUT_W'({out_pixel, out_address});

endmodule

### hdl/rtcb_checker.sv
// Port-level checks of the RLE clip blitter, bound to the top level.
// Depends on rtcb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtcb_checker #(
	parameter int ADDR_BITS = rtcb_pkg::ADDR_BITS_DEF
) (
	input logic                                       clk,
	input logic                                       arst_n,
	input logic                                       m_axis_tvalid,
	input logic                                       m_axis_tready,
	input logic [((ADDR_BITS + 8 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

	logic [7:0] pixel;

	assign pixel = m_axis_tdata[ADDR_BITS +: 8];

	`RTCB_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result transaction dropped while stalled")
	`RTCB_ASSERT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")
	`RTCB_ASSERT(a_pixel_opaque, clk, arst_n, m_axis_tvalid |-> pixel < rtcb_pkg::TRANSPARENT_MIN, "transparent code written as a pixel")
	`RTCB_ASSERT_ALWAYS(a_reset_quiet, clk, $past(!arst_n) |-> !m_axis_tvalid, "result valid right after reset")

endmodule

bind rle_transparent_clip_blit rtcb_checker #(.ADDR_BITS(ADDR_BITS)) u_rtcb_checker (.*);
